// File: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sacl_pkg.sv
// shared types, constants and helper functions of the cache lookup block
package sacl_pkg;

    // sizing of the set memories
    localparam int MAX_SETS = 1024;
    localparam int MAX_WAYS = 8;

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int BCNT_W = 6;
    localparam int SET_W  = 10;
    localparam int WAY_W  = 3;
    localparam int TAG_W  = 30;
    localparam int CNT_W  = 32;
    localparam int CYC_W  = 40;
    localparam int VCNT_W = 14;
    localparam int KIND_W = 2;
    localparam int LFSR_W = 16;
    localparam int OB_W   = 3;
    localparam int IB_W   = 4;
    localparam int WCFG_W = 4;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 2;

    // front-end arithmetic widths
    localparam int OFF_W  = 6;
    localparam int SPAN_W = 8;
    localparam int NBLK_W = 4;

    // derived memory geometry
    localparam int IDX_LIM   = ($clog2(MAX_SETS) < SET_W) ? $clog2(MAX_SETS) : SET_W;
    localparam int MEM_AW    = (IDX_LIM > 0) ? IDX_LIM : 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int WAYS      = (MAX_WAYS < (1 << WAY_W)) ? MAX_WAYS : (1 << WAY_W);
    localparam int WAY_IW    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // remainder unit: bits retired per cycle
    localparam int REM_DIGITS = 4;
    localparam int REM_STEPS  = LFSR_W / REM_DIGITS;
    localparam int REM_CW     = (REM_STEPS > 1) ? $clog2(REM_STEPS) : 1;

    // clamp limits and reset values of the registers
    localparam logic [OB_W-1:0]   OB_MIN    = 3'd2;
    localparam logic [OB_W-1:0]   OB_MAX    = 3'd6;
    localparam logic [IB_W-1:0]   IB_LIM    = IB_W'(IDX_LIM);
    localparam logic [WCFG_W-1:0] WAYS_LIM  = WCFG_W'(WAYS);
    localparam logic [WCFG_W-1:0] WAYS_MIN  = 4'd1;
    localparam logic [OB_W-1:0]   OB_RST    = 3'd4;
    localparam logic [IB_W-1:0]   IB_RST    = 4'd6;
    localparam logic [WCFG_W-1:0] WAYS_RST  = 4'd1;
    localparam logic [BCNT_W-1:0] BCNT_LIM  = 6'd32;

    // counter limits and lfsr seed
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
    localparam logic [CYC_W-1:0]  CYC_MAX   = '1;
    localparam logic [VCNT_W-1:0] VCNT_MAX  = '1;
    localparam logic [CYC_W-1:0]  CYC_HIT   = 40'd1;
    localparam logic [CYC_W-1:0]  CYC_MISS  = 40'd3;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_BITS  = 2'd0,
        REG_INDEX_BITS   = 2'd1,
        REG_WAYS_IN_USE  = 2'd2,
        REG_REPLACE_MODE = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        MODE_RR     = 1'b0,
        MODE_RANDOM = 1'b1
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT        = 2'd0,
        KIND_COMPULSORY = 2'd1,
        KIND_CONFLICT   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_LOOK,
        B_REM
    } back_state_t;

    typedef struct packed {
        logic [OB_W-1:0]   ob;
        logic [IB_W-1:0]   ib;
        logic [WCFG_W-1:0] ways;
        mode_t             mode;
    } cfg_t;

    // one block of an access, as handed from front to back
    typedef struct packed {
        logic [SET_W-1:0] set;
        logic [TAG_W-1:0] tag;
        logic             last;
    } blk_cmd_t;

    // per-set control row: round robin pointer and way valid bits
    typedef struct packed {
        logic [WAY_W-1:0] ptr;
        logic [WAYS-1:0]  valid;
    } meta_t;

    // bring register values into their legal ranges
    function automatic cfg_t cfg_clamp(cfg_t raw);
        cfg_t c;
        c = raw;
        if (raw.ob < OB_MIN) begin
            c.ob = OB_MIN;
        end else if (raw.ob > OB_MAX) begin
            c.ob = OB_MAX;
        end
        if (raw.ib > IB_LIM) begin
            c.ib = IB_LIM;
        end
        if (raw.ways < WAYS_MIN) begin
            c.ways = WAYS_MIN;
        end else if (raw.ways > WAYS_LIM) begin
            c.ways = WAYS_LIM;
        end
        return c;
    endfunction

    // 16-bit fibonacci lfsr, taps 16 14 13 11, shifting right
    function automatic logic [LFSR_W-1:0] lfsr_step(logic [LFSR_W-1:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[LFSR_W-1:1]};
    endfunction

endpackage

// File: rtl/sacl_in_if.sv
// input channel: one access item, address and byte count
interface sacl_in_if import sacl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic [BCNT_W-1:0] byte_count;

    modport source (output valid, output address, output byte_count, input ready);
    modport sink   (input valid, input address, input byte_count, output ready);
endinterface

// File: rtl/sacl_out_if.sv
// output channel: one result item per cache block touched
interface sacl_out_if import sacl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] miss_kind;
    logic [SET_W-1:0]  set_number;
    logic [WAY_W-1:0]  way_number;
    logic              last_block;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  compulsory_total;
    logic [CNT_W-1:0]  conflict_total;
    logic [CNT_W-1:0]  access_total;
    logic [CYC_W-1:0]  cycle_total;
    logic [VCNT_W-1:0] valid_blocks;

    modport source (
        output valid, output miss_kind, output set_number, output way_number,
        output last_block, output hit_total, output compulsory_total,
        output conflict_total, output access_total, output cycle_total,
        output valid_blocks, input ready
    );
    modport sink (
        input valid, input miss_kind, input set_number, input way_number,
        input last_block, input hit_total, input compulsory_total,
        input conflict_total, input access_total, input cycle_total,
        input valid_blocks, output ready
    );
endinterface

// File: rtl/set_assoc_cache_lookup_top.sv
// Set-associative cache tag lookup. After reset the block sweeps its set
// control memory, one set per cycle, over all 1024 sets, and accepts no access
// meanwhile (register writes are taken). An access is split into 0 to 9
// blocks (none for a zero byte count); each block gives one result item.
// A block takes a set memory read, then a compare and, on a miss, a write-back
// into the same set; on a random miss the victim is first found as the lfsr
// value reduced by the way count in a remainder unit retiring four bits a cycle.
// The front end splits the next access while the back end works. A finished
// result waits in an output register; the next block's set read goes ahead,
// but its result is not committed until that register is free.
module set_assoc_cache_lookup_top import sacl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    sacl_in_if.sink               in_ch,
    sacl_out_if.source            out_ch,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    logic [OB_W-1:0]   ob_reg;
    logic [IB_W-1:0]   ib_reg;
    logic [WCFG_W-1:0] ways_reg;
    mode_t             mode_reg;
    cfg_t              cfg_raw;
    cfg_t              cfg;

    blk_cmd_t          f_cmd;
    logic              f_valid;
    logic              f_ready;
    blk_cmd_t          b_cmd;
    logic              b_valid;
    logic              b_ready;
    logic              init_done;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ob_reg   <= OB_RST;
            ib_reg   <= IB_RST;
            ways_reg <= WAYS_RST;
            mode_reg <= MODE_RR;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_OFFSET_BITS:  ob_reg   <= cfg_wr_data[OB_W-1:0];
                REG_INDEX_BITS:   ib_reg   <= cfg_wr_data[IB_W-1:0];
                REG_WAYS_IN_USE:  ways_reg <= cfg_wr_data[WCFG_W-1:0];
                REG_REPLACE_MODE: mode_reg <= mode_t'(cfg_wr_data[0]);
                default:          ob_reg   <= ob_reg;
            endcase
        end
    end

    // clamped view of the registers
    always_comb
    begin
        cfg_raw.ob   = ob_reg;
        cfg_raw.ib   = ib_reg;
        cfg_raw.ways = ways_reg;
        cfg_raw.mode = mode_reg;
        cfg          = cfg_clamp(cfg_raw);
    end

    sacl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .init_done (init_done),
        .in_ch     (in_ch),
        .cmd       (f_cmd),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready)
    );

    sacl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (f_cmd),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_cmd   (b_cmd),
        .rd_valid (b_valid),
        .rd_ready (b_ready)
    );

    sacl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (b_cmd),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .init_done (init_done),
        .out_ch    (out_ch)
    );

endmodule

// File: rtl/sacl_front.sv
// front end: takes an access and splits it into block commands
module sacl_front import sacl_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     init_done,
    sacl_in_if.sink  in_ch,
    output blk_cmd_t cmd,
    output logic     cmd_valid,
    input  logic     cmd_ready
);

    logic [TAG_W-1:0]  blk_reg, blk_next;
    logic [NBLK_W-1:0] left_reg, left_next;
    logic [OFF_W-1:0]  bs_m1;
    logic [OFF_W-1:0]  off;
    logic [BCNT_W-1:0] bc_clip;
    logic [SPAN_W-1:0] span;
    logic [NBLK_W-1:0] n_calc;
    logic [TAG_W-1:0]  blk0;
    logic [TAG_W-1:0]  blk_mask;
    logic [SET_W-1:0]  set_mask;
    logic              accept;

    // block count and first block number of the incoming access
    always_comb
    begin
        bs_m1    = OFF_W'((7'd1 << cfg.ob) - 7'd1);
        off      = in_ch.address[OFF_W-1:0] & bs_m1;
        bc_clip  = (in_ch.byte_count > BCNT_LIM) ? BCNT_LIM : in_ch.byte_count;
        span     = SPAN_W'(off) + SPAN_W'(bc_clip) + SPAN_W'(bs_m1);
        n_calc   = (in_ch.byte_count == '0) ? '0 : NBLK_W'(span >> cfg.ob);
        blk0     = TAG_W'(in_ch.address >> cfg.ob);
        blk_mask = {TAG_W{1'b1}} >> (cfg.ob - OB_MIN);
        set_mask = SET_W'((11'd1 << cfg.ib) - 11'd1);
    end

    // take a new access only once the previous one is fully split
    assign in_ch.ready = init_done && (left_reg == '0);
    assign accept      = in_ch.valid && in_ch.ready;

    // current block split into set and tag
    assign cmd_valid = (left_reg != '0);
    assign cmd.set   = SET_W'(blk_reg) & set_mask;
    assign cmd.tag   = blk_reg >> cfg.ib;
    assign cmd.last  = (left_reg == NBLK_W'(1));

    // walk the block number, wrapping within the address space
    always_comb
    begin
        blk_next  = blk_reg;
        left_next = left_reg;
        if (accept) begin
            blk_next  = blk0;
            left_next = n_calc;
        end else if (cmd_valid && cmd_ready) begin
            blk_next  = (blk_reg + TAG_W'(1)) & blk_mask;
            left_next = left_reg - NBLK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_reg <= '0;
        end else begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

// File: rtl/sacl_queue.sv
// small fifo of block commands between front and back
module sacl_queue import sacl_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  blk_cmd_t wr_cmd,
    input  logic     wr_valid,
    output logic     wr_ready,
    output blk_cmd_t rd_cmd,
    output logic     rd_valid,
    input  logic     rd_ready
);

    localparam int QDEPTH = 2;
    localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W   = $clog2(QDEPTH + 1);

    blk_cmd_t          entry_reg [QDEPTH];
    logic [QA_W-1:0]   wp_reg, wp_next;
    logic [QA_W-1:0]   rp_reg, rp_next;
    logic [QC_W-1:0]   cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign wr_ready = (cnt_reg != QC_W'(QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd   = entry_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == QA_W'(QDEPTH - 1)) ? '0 : wp_reg + QA_W'(1);
        end
        if (pop) begin
            rp_next = (rp_reg == QA_W'(QDEPTH - 1)) ? '0 : rp_reg + QA_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + QC_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wp_reg] <= wr_cmd;
        end
    end

endmodule

// File: rtl/sacl_rem.sv
// iterative remainder of the lfsr value by the way count, four bits a cycle
module sacl_rem import sacl_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LFSR_W-1:0] dividend,
    input  logic [WCFG_W-1:0] divisor,
    output logic              busy,
    output logic [WAY_W-1:0]  rem
);

    logic [LFSR_W-1:0] sh_reg, sh_next;
    logic [WAY_W-1:0]  r_reg, r_next;
    logic [REM_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;

    // restoring steps on the top digits of the shift register
    always_comb
    begin
        logic [WAY_W:0] r;
        sh_next   = sh_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        r         = {1'b0, r_reg};
        if (start) begin
            sh_next   = dividend;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            for (int j = 0; j < REM_DIGITS; j++) begin
                r = {r[WAY_W-1:0], sh_reg[LFSR_W-1-j]};
                if (r >= divisor) begin
                    r = r - divisor;
                end
            end
            r_next   = r[WAY_W-1:0];
            sh_next  = sh_reg << REM_DIGITS;
            cnt_next = cnt_reg + REM_CW'(1);
            if (cnt_reg == REM_CW'(REM_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        r_reg  <= r_next;
    end

    assign busy = busy_reg;
    assign rem  = r_reg;

endmodule

// File: rtl/sacl_back.sv
// back end: set memories, hit and victim logic, counters and result register
module sacl_back import sacl_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  blk_cmd_t  cmd,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    output logic      init_done,
    sacl_out_if.source out_ch
);

    localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);

    back_state_t state_reg, state_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;
    blk_cmd_t          cur_reg, cur_next;

    // set memories: control row (cleared after reset) and tag row
    meta_t                         meta_mem [MEM_DEPTH];
    logic [WAYS-1:0][TAG_W-1:0]    tag_mem  [MEM_DEPTH];
    meta_t                         meta_rd_reg;
    logic [WAYS-1:0][TAG_W-1:0]    tag_rd_reg;
    logic                          rd_en;
    logic [MEM_AW-1:0]             rd_addr;
    logic                          meta_we;
    logic [MEM_AW-1:0]             meta_wa;
    meta_t                         meta_wd;
    logic                          tag_we;

    // lookup and victim choice
    logic [WAYS-1:0]   match;
    logic              hit;
    logic              hit_now;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  rr_way;
    logic [WCFG_W-1:0] rr_inc;
    logic [WAY_W-1:0]  rr_ptr_next;
    logic [WAY_W-1:0]  commit_way;
    logic              was_valid;
    kind_t             kind;
    logic              commit;
    logic              slot_free;

    // random victim
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic              rem_start;
    logic              rem_busy;
    logic [WAY_W-1:0]  rem_way;

    // running counters
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]  comp_cnt_reg, comp_cnt_next;
    logic [CNT_W-1:0]  conf_cnt_reg, conf_cnt_next;
    logic [CNT_W-1:0]  acc_cnt_reg, acc_cnt_next;
    logic [CYC_W-1:0]  cyc_cnt_reg, cyc_cnt_next;
    logic [VCNT_W-1:0] vld_cnt_reg, vld_cnt_next;
    logic [CYC_W-1:0]  cyc_add;

    // result register
    logic              out_valid_reg, out_valid_next;
    kind_t             o_kind_reg;
    logic [SET_W-1:0]  o_set_reg;
    logic [WAY_W-1:0]  o_way_reg;
    logic              o_last_reg;
    logic [CNT_W-1:0]  o_hit_reg;
    logic [CNT_W-1:0]  o_comp_reg;
    logic [CNT_W-1:0]  o_conf_reg;
    logic [CNT_W-1:0]  o_acc_reg;
    logic [CYC_W-1:0]  o_cyc_reg;
    logic [VCNT_W-1:0] o_vld_reg;

    sacl_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (lfsr_next),
        .divisor  (cfg.ways),
        .busy     (rem_busy),
        .rem      (rem_way)
    );

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign init_done = (state_reg != B_CLEAR);

    // hit search over the ways in use, lowest way wins
    always_comb
    begin
        for (int i = 0; i < WAYS; i++) begin
            match[i] = meta_rd_reg.valid[i] && (tag_rd_reg[i] == cur_reg.tag) &&
                       (WCFG_W'(i) < cfg.ways);
        end
        hit     = |match;
        hit_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = WAY_W'(i);
            end
        end
    end

    // round robin victim and pointer advance
    always_comb
    begin
        rr_way      = (WCFG_W'(meta_rd_reg.ptr) >= cfg.ways) ? '0 : meta_rd_reg.ptr;
        rr_inc      = WCFG_W'(rr_way) + WCFG_W'(1);
        rr_ptr_next = (rr_inc == cfg.ways) ? '0 : rr_inc[WAY_W-1:0];
    end

    // sequencer: clear pass, fetch, look up, wait for random victim
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        rd_en      = 1'b0;
        rd_addr    = cmd.set[MEM_AW-1:0];
        cmd_ready  = 1'b0;
        commit     = 1'b0;
        rem_start  = 1'b0;
        lfsr_next  = lfsr_reg;
        case (state_reg)
            B_CLEAR:
            begin
                clr_next = clr_reg + MEM_AW'(1);
                if (clr_reg == MEM_LAST) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cur_next   = cmd;
                    rd_en      = 1'b1;
                    state_next = B_LOOK;
                end
            end
            B_LOOK:
            begin
                if (hit || (cfg.mode == MODE_RR)) begin
                    if (slot_free) begin
                        commit     = 1'b1;
                        state_next = B_IDLE;
                    end
                end else begin
                    lfsr_next  = lfsr_step(lfsr_reg);
                    rem_start  = 1'b1;
                    state_next = B_REM;
                end
            end
            B_REM:
            begin
                if (!rem_busy && slot_free) begin
                    commit     = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    // outcome of the block being retired
    always_comb
    begin
        hit_now = hit && (state_reg == B_LOOK);
        if (hit_now) begin
            commit_way = hit_way;
        end else if (state_reg == B_REM) begin
            commit_way = rem_way;
        end else begin
            commit_way = rr_way;
        end
        was_valid = meta_rd_reg.valid[commit_way[WAY_IW-1:0]];
        if (hit_now) begin
            kind = KIND_HIT;
        end else if (was_valid) begin
            kind = KIND_CONFLICT;
        end else begin
            kind = KIND_COMPULSORY;
        end
    end

    // memory write-back: clear pass or fill
    always_comb
    begin
        meta_we = 1'b0;
        meta_wa = cur_reg.set[MEM_AW-1:0];
        meta_wd = meta_rd_reg;
        tag_we  = commit && !hit_now;
        if (state_reg == B_CLEAR) begin
            meta_we = 1'b1;
            meta_wa = clr_reg;
            meta_wd = '0;
        end else if (commit && !hit_now) begin
            meta_we = 1'b1;
            meta_wd.valid[commit_way[WAY_IW-1:0]] = 1'b1;
            if (cfg.mode == MODE_RR) begin
                meta_wd.ptr = rr_ptr_next;
            end
        end
    end

    // saturating counter updates
    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        comp_cnt_next = comp_cnt_reg;
        conf_cnt_next = conf_cnt_reg;
        acc_cnt_next  = acc_cnt_reg;
        cyc_cnt_next  = cyc_cnt_reg;
        vld_cnt_next  = vld_cnt_reg;
        cyc_add       = hit_now ? CYC_HIT : CYC_MISS;
        if (commit) begin
            case (kind)
                KIND_HIT:
                begin
                    if (hit_cnt_reg != CNT_MAX) begin
                        hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                    end
                end
                KIND_COMPULSORY:
                begin
                    if (comp_cnt_reg != CNT_MAX) begin
                        comp_cnt_next = comp_cnt_reg + CNT_W'(1);
                    end
                    if (vld_cnt_reg != VCNT_MAX) begin
                        vld_cnt_next = vld_cnt_reg + VCNT_W'(1);
                    end
                end
                KIND_CONFLICT:
                begin
                    if (conf_cnt_reg != CNT_MAX) begin
                        conf_cnt_next = conf_cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    hit_cnt_next = hit_cnt_reg;
                end
            endcase
            if (acc_cnt_reg != CNT_MAX) begin
                acc_cnt_next = acc_cnt_reg + CNT_W'(1);
            end
            cyc_cnt_next = (cyc_cnt_reg >= CYC_MAX - cyc_add) ? CYC_MAX
                                                              : cyc_cnt_reg + cyc_add;
        end
    end

    // result register hand-off
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit) begin
            out_valid_next = 1'b1;
        end else if (out_ch.ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            lfsr_reg      <= LFSR_SEED;
            hit_cnt_reg   <= '0;
            comp_cnt_reg  <= '0;
            conf_cnt_reg  <= '0;
            acc_cnt_reg   <= '0;
            cyc_cnt_reg   <= '0;
            vld_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lfsr_reg      <= lfsr_next;
            hit_cnt_reg   <= hit_cnt_next;
            comp_cnt_reg  <= comp_cnt_next;
            conf_cnt_reg  <= conf_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
            cyc_cnt_reg   <= cyc_cnt_next;
            vld_cnt_reg   <= vld_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: current block and result fields
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (commit) begin
            o_kind_reg <= kind;
            o_set_reg  <= cur_reg.set;
            o_way_reg  <= commit_way;
            o_last_reg <= cur_reg.last;
            o_hit_reg  <= hit_cnt_next;
            o_comp_reg <= comp_cnt_next;
            o_conf_reg <= conf_cnt_next;
            o_acc_reg  <= acc_cnt_next;
            o_cyc_reg  <= cyc_cnt_next;
            o_vld_reg  <= vld_cnt_next;
        end
    end

    // control row memory
    always_ff @(posedge clk)
    begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (rd_en) begin
            meta_rd_reg <= meta_mem[rd_addr];
        end
    end

    // tag row memory, one way written per fill
    always_ff @(posedge clk)
    begin
        if (tag_we) begin
            tag_mem[cur_reg.set[MEM_AW-1:0]][commit_way[WAY_IW-1:0]] <= cur_reg.tag;
        end
        if (rd_en) begin
            tag_rd_reg <= tag_mem[rd_addr];
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.miss_kind        = o_kind_reg;
    assign out_ch.set_number       = o_set_reg;
    assign out_ch.way_number       = o_way_reg;
    assign out_ch.last_block       = o_last_reg;
    assign out_ch.hit_total        = o_hit_reg;
    assign out_ch.compulsory_total = o_comp_reg;
    assign out_ch.conflict_total   = o_conf_reg;
    assign out_ch.access_total     = o_acc_reg;
    assign out_ch.cycle_total      = o_cyc_reg;
    assign out_ch.valid_blocks     = o_vld_reg;

endmodule

// File: rtl/sacl_checker.sv
// port-level checks of the cache lookup block, bound to the top level
`include "assert_macros.svh"

module sacl_checker import sacl_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [KIND_W-1:0] miss_kind,
    input logic [SET_W-1:0]  set_number,
    input logic [WAY_W-1:0]  way_number,
    input logic [CNT_W-1:0]  hit_total,
    input logic [CNT_W-1:0]  compulsory_total,
    input logic [CNT_W-1:0]  conflict_total,
    input logic [CNT_W-1:0]  access_total,
    input logic [CYC_W-1:0]  cycle_total,
    input logic [VCNT_W-1:0] valid_blocks
);

    // a stalled result item stays put
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(access_total) && $stable(set_number) && $stable(way_number) && $stable(miss_kind), "result item changed while stalled")

    // every block is a hit or one kind of miss
    `ASSERT_IMPL(a_access_sum, out_valid && (access_total != CNT_MAX), (34'(hit_total) + 34'(compulsory_total) + 34'(conflict_total)) == 34'(access_total), "access total does not match hits plus misses")

    // cycle total: hit total plus three times the miss totals
    `ASSERT_IMPL(a_cycle_sum, out_valid && (access_total != CNT_MAX) && (cycle_total != CYC_MAX), cycle_total == (40'(hit_total) + 40'(3) * (40'(compulsory_total) + 40'(conflict_total))), "cycle total does not match hit and miss totals")

    // every compulsory fill adds one valid block
    `ASSERT_IMPL(a_valid_fill, out_valid && (compulsory_total < 32'(VCNT_MAX)), 32'(valid_blocks) == compulsory_total, "valid block count differs from compulsory fills")

endmodule

bind set_assoc_cache_lookup_top sacl_checker u_sacl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .miss_kind        (out_ch.miss_kind),
    .set_number       (out_ch.set_number),
    .way_number       (out_ch.way_number),
    .hit_total        (out_ch.hit_total),
    .compulsory_total (out_ch.compulsory_total),
    .conflict_total   (out_ch.conflict_total),
    .access_total     (out_ch.access_total),
    .cycle_total      (out_ch.cycle_total),
    .valid_blocks     (out_ch.valid_blocks)
);

// File: test/tb_set_assoc_cache_lookup_top.sv
// testbench for the set-associative cache lookup: directed table, random phases, self-checking
module tb_set_assoc_cache_lookup_top;
    import sacl_pkg::*;

    localparam int SETTLE_CYCLES = 100;

    // one block result as seen on the output channel
    typedef struct packed {
        kind_t             kind;
        logic [SET_W-1:0]  set_number;
        logic [WAY_W-1:0]  way_number;
        logic              last_block;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  compulsory_total;
        logic [CNT_W-1:0]  conflict_total;
        logic [CNT_W-1:0]  access_total;
        logic [CYC_W-1:0]  cycle_total;
        logic [VCNT_W-1:0] valid_blocks;
    } block_result_t;

    // one row of the directed table: a register write or an access
    typedef struct {
        bit                  is_reg;
        cfg_reg_t            reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ADDR_W-1:0]   addr;
        logic [BCNT_W-1:0]   bc;
        bit                  typed;
        bit                  want_any;
        block_result_t       want;
    } probe_row_t;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    sacl_in_if  in_ch ();
    sacl_out_if out_ch ();

    set_assoc_cache_lookup_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // shadow tag store and settings
    logic [TAG_W-1:0]  tag_mem [MAX_SETS][MAX_WAYS];
    logic [MAX_WAYS-1:0] valid_map [MAX_SETS];
    logic [WAY_W-1:0]  rr_ptr [MAX_SETS];
    logic [LFSR_W-1:0] lfsr_val;
    logic [CNT_W-1:0]  hit_count, compulsory_count, conflict_count, access_count;
    logic [CYC_W-1:0]  cycle_count;
    logic [VCNT_W-1:0] valid_count;
    logic [OB_W-1:0]   cfg_ob;
    logic [IB_W-1:0]   cfg_ib;
    logic [WCFG_W-1:0] cfg_ways;
    mode_t             cfg_mode;

    block_result_t fresh_blocks [$];
    block_result_t blocks_due [$];
    probe_row_t    probe_rows [$];
    logic [ADDR_W-1:0] hot_base [6];

    int mismatches = 0;
    int accesses_sent = 0;
    int results_seen = 0;
    int settings_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("tb_set_assoc_cache_lookup_top: errors");
        $finish;
    end

    // receiver back-pressure
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // walk the blocks of one access through the shadow store
    function automatic void lookup_blocks(input logic [ADDR_W-1:0] addr,
                                          input logic [BCNT_W-1:0] bc_in);
        int unsigned bc, ob, ib, w, nblk, way, k, i;
        logic [31:0] base, blk, set_idx, tag_val;
        logic hit;
        block_result_t r;
        fresh_blocks.delete();
        if (bc_in == 0)
        begin
            return;
        end
        bc = (bc_in > 6'd32) ? 32 : bc_in;
        ob = (cfg_ob < 2) ? 2 : ((cfg_ob > 6) ? 6 : cfg_ob);
        ib = (cfg_ib > 10) ? 10 : cfg_ib;
        w = (cfg_ways < 1) ? 1 : ((cfg_ways > 8) ? 8 : cfg_ways);
        base = addr & ~((32'd1 << ob) - 32'd1);
        nblk = ((addr & ((32'd1 << ob) - 32'd1)) + bc + (32'd1 << ob) - 1) >> ob;
        for (k = 0; k < nblk; k++)
        begin
            blk = base + 32'(k << ob);
            blk = blk >> ob;
            set_idx = blk & ((32'd1 << ib) - 32'd1);
            tag_val = blk >> ib;
            hit = 1'b0;
            way = 0;
            // lowest valid matching way wins
            for (i = 0; i < w; i++)
            begin
                if (!hit && valid_map[set_idx][i] && tag_mem[set_idx][i] == tag_val[TAG_W-1:0])
                begin
                    hit = 1'b1;
                    way = i;
                end
            end
            if (hit)
            begin
                r.kind = KIND_HIT;
                if (hit_count != CNT_MAX) hit_count++;
                if (cycle_count != CYC_MAX) cycle_count++;
            end
            else
            begin
                // victim choice
                if (cfg_mode == MODE_RR)
                begin
                    way = rr_ptr[set_idx];
                    if (way >= w) way = 0;
                    rr_ptr[set_idx] = (way + 1 == w) ? '0 : WAY_W'(way + 1);
                end
                else
                begin
                    lfsr_val = {lfsr_val[0] ^ lfsr_val[2] ^ lfsr_val[3] ^ lfsr_val[5],
                                lfsr_val[LFSR_W-1:1]};
                    way = lfsr_val % w;
                end
                if (!valid_map[set_idx][way])
                begin
                    r.kind = KIND_COMPULSORY;
                    if (compulsory_count != CNT_MAX) compulsory_count++;
                    if (valid_count != VCNT_MAX) valid_count++;
                end
                else
                begin
                    r.kind = KIND_CONFLICT;
                    if (conflict_count != CNT_MAX) conflict_count++;
                end
                tag_mem[set_idx][way] = tag_val[TAG_W-1:0];
                valid_map[set_idx][way] = 1'b1;
                cycle_count = (cycle_count >= CYC_MAX - CYC_MISS) ? CYC_MAX : cycle_count + CYC_MISS;
            end
            if (access_count != CNT_MAX) access_count++;
            r.set_number = set_idx[SET_W-1:0];
            r.way_number = way[WAY_W-1:0];
            r.last_block = (k + 1 == nblk);
            r.hit_total = hit_count;
            r.compulsory_total = compulsory_count;
            r.conflict_total = conflict_count;
            r.access_total = access_count;
            r.cycle_total = cycle_count;
            r.valid_blocks = valid_count;
            fresh_blocks.push_back(r);
        end
    endfunction

    function automatic block_result_t typed_result(kind_t kind, int set_idx, int way, bit last,
                                                   longint h, longint c, longint f, longint a,
                                                   longint cy, longint v);
        block_result_t r;
        r.kind = kind;
        r.set_number = SET_W'(set_idx);
        r.way_number = WAY_W'(way);
        r.last_block = last;
        r.hit_total = CNT_W'(h);
        r.compulsory_total = CNT_W'(c);
        r.conflict_total = CNT_W'(f);
        r.access_total = CNT_W'(a);
        r.cycle_total = CYC_W'(cy);
        r.valid_blocks = VCNT_W'(v);
        return r;
    endfunction

    function automatic void push_access(logic [ADDR_W-1:0] addr, logic [BCNT_W-1:0] bc);
        probe_row_t p;
        p = '{default: '0, reg_sel: REG_OFFSET_BITS};
        p.addr = addr;
        p.bc = bc;
        probe_rows.push_back(p);
    endfunction

    function automatic void push_typed(logic [ADDR_W-1:0] addr, logic [BCNT_W-1:0] bc,
                                       bit want_any, block_result_t want);
        probe_row_t p;
        p = '{default: '0, reg_sel: REG_OFFSET_BITS};
        p.addr = addr;
        p.bc = bc;
        p.typed = 1'b1;
        p.want_any = want_any;
        p.want = want;
        probe_rows.push_back(p);
    endfunction

    function automatic void push_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
        probe_row_t p;
        p = '{default: '0, reg_sel: REG_OFFSET_BITS};
        p.is_reg = 1'b1;
        p.reg_sel = sel;
        p.reg_val = val;
        probe_rows.push_back(p);
    endfunction

    task automatic check_field(string name, logic [CYC_W-1:0] want, logic [CYC_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // write one register and mirror it in the shadow settings
    task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wr_data <= val;
        @(posedge clk);
        case (sel)
            REG_OFFSET_BITS:  cfg_ob = val[OB_W-1:0];
            REG_INDEX_BITS:   cfg_ib = val;
            REG_WAYS_IN_USE:  cfg_ways = val;
            REG_REPLACE_MODE: cfg_mode = mode_t'(val[0]);
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // let every pending block drain, then a margin for zero-block accesses
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (blocks_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // offer one access item, predict its blocks once accepted
    task automatic send_access(logic [ADDR_W-1:0] addr, logic [BCNT_W-1:0] bc,
                               bit typed, bit want_any, block_result_t want);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.address <= addr;
        in_ch.byte_count <= bc;
        do
        begin
            @(posedge clk);
        end
        while (in_ch.ready !== 1'b1);
        lookup_blocks(addr, bc);
        if (typed)
        begin
            if (want_any) blocks_due.push_back(want);
        end
        else
        begin
            foreach (fresh_blocks[j]) blocks_due.push_back(fresh_blocks[j]);
        end
        accesses_sent++;
    endtask

    // one random phase under one register setting and one pacing
    task automatic run_phase(int ob, int ib, int ways, mode_t mode,
                             int src_pct, int sink_pct, int count);
        logic [ADDR_W-1:0] addr, prev_addr;
        logic [BCNT_W-1:0] bc;
        int span, pick, obe;
        wait_idle();
        write_reg(REG_OFFSET_BITS, CFG_DATA_W'(ob));
        write_reg(REG_INDEX_BITS, CFG_DATA_W'(ib));
        write_reg(REG_WAYS_IN_USE, CFG_DATA_W'(ways));
        write_reg(REG_REPLACE_MODE, CFG_DATA_W'(mode));
        settings_count++;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        // region 0 stays across phases so old contents get revisited
        for (int j = 1; j < 6; j++) hot_base[j] = $urandom();
        obe = (ob < 2) ? 2 : ((ob > 6) ? 6 : ob);
        span = 16 << obe;
        prev_addr = hot_base[0];
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                addr = prev_addr;
            else if (pick < 8)
                addr = hot_base[$urandom_range(0, 5)] + $urandom_range(0, span - 1);
            else
                addr = $urandom();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                bc = '0;
            else if (pick == 1)
                bc = BCNT_W'($urandom_range(33, 63));
            else
                bc = BCNT_W'($urandom_range(1, 32));
            send_access(addr, bc, 1'b0, 1'b0, '0);
            prev_addr = addr;
        end
    endtask

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        block_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (blocks_due.size() == 0)
            begin
                $error("block result with none pending: set %0d way %0d",
                       out_ch.set_number, out_ch.way_number);
                mismatches++;
            end
            else
            begin
                want = blocks_due.pop_front();
                check_field("miss_kind", want.kind, out_ch.miss_kind);
                check_field("set_number", want.set_number, out_ch.set_number);
                check_field("way_number", want.way_number, out_ch.way_number);
                check_field("last_block", want.last_block, out_ch.last_block);
                check_field("hit_total", want.hit_total, out_ch.hit_total);
                check_field("compulsory_total", want.compulsory_total, out_ch.compulsory_total);
                check_field("conflict_total", want.conflict_total, out_ch.conflict_total);
                check_field("access_total", want.access_total, out_ch.access_total);
                check_field("cycle_total", want.cycle_total, out_ch.cycle_total);
                check_field("valid_blocks", want.valid_blocks, out_ch.valid_blocks);
                results_seen++;
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_OFFSET_BITS;
        cfg_wr_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.address <= '0;
        in_ch.byte_count <= '0;
        for (int s = 0; s < MAX_SETS; s++)
        begin
            valid_map[s] = '0;
            rr_ptr[s] = '0;
            for (int w = 0; w < MAX_WAYS; w++) tag_mem[s][w] = '0;
        end
        lfsr_val = LFSR_SEED;
        hit_count = '0;
        compulsory_count = '0;
        conflict_count = '0;
        access_count = '0;
        cycle_count = '0;
        valid_count = '0;
        cfg_ob = OB_RST;
        cfg_ib = IB_RST;
        cfg_ways = WAYS_RST;
        cfg_mode = MODE_RR;
        hot_base[0] = $urandom();

        // first accesses at reset settings: results read off directly
        push_typed(32'h0000_0000, 6'd1, 1'b1,
                   typed_result(KIND_COMPULSORY, 0, 0, 1, 0, 1, 0, 1, 3, 1));
        push_typed(32'h0000_0000, 6'd1, 1'b1,
                   typed_result(KIND_HIT, 0, 0, 1, 1, 1, 0, 2, 4, 1));
        push_typed(32'h0000_000F, 6'd1, 1'b1,
                   typed_result(KIND_HIT, 0, 0, 1, 2, 1, 0, 3, 5, 1));
        push_typed(32'h0000_0400, 6'd1, 1'b1,
                   typed_result(KIND_CONFLICT, 0, 0, 1, 2, 1, 1, 4, 8, 1));
        // zero byte count gives nothing
        push_typed(32'h0000_0123, 6'd0, 1'b0, '0);
        // wrap past the top of the address space, count clamp
        push_access(32'hFFFF_FFFF, 6'd32);
        push_access(32'hFFFF_FFF0, 6'd63);
        push_access(32'h0000_03F8, 6'd33);
        // smallest blocks, one set, all ways: up to nine blocks per access
        push_reg(REG_OFFSET_BITS, 4'd2);
        push_reg(REG_WAYS_IN_USE, 4'd8);
        push_reg(REG_INDEX_BITS, 4'd0);
        push_access(32'h0000_0003, 6'd32);
        push_access(32'h0000_0003, 6'd32);
        push_access(32'h0000_1000, 6'd32);
        // lfsr victims
        push_reg(REG_REPLACE_MODE, 4'd1);
        push_access(32'h2000_0000, 6'd32);
        push_access(32'h2000_0000, 6'd32);
        // out-of-range register values clamp
        push_reg(REG_OFFSET_BITS, 4'd7);
        push_reg(REG_INDEX_BITS, 4'd15);
        push_reg(REG_WAYS_IN_USE, 4'd0);
        push_access(32'h5555_5555, 6'd21);
        push_access(32'hAAAA_AAAA, 6'd42);
        push_reg(REG_OFFSET_BITS, 4'd0);
        push_reg(REG_WAYS_IN_USE, 4'd15);
        push_reg(REG_INDEX_BITS, 4'd10);
        push_reg(REG_REPLACE_MODE, 4'd0);
        push_access(32'hAAAA_AAAA, 6'd1);
        push_access(32'h0000_0FFC, 6'd8);
        // fewer ways: pointers past the last way fall back to way 0
        push_reg(REG_WAYS_IN_USE, 4'd3);
        push_access(32'h0000_0003, 6'd32);
        push_access(32'h0000_0003, 6'd32);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (probe_rows[r])
        begin
            if (probe_rows[r].is_reg)
            begin
                wait_idle();
                write_reg(probe_rows[r].reg_sel, probe_rows[r].reg_val);
                settings_count++;
            end
            else
            begin
                send_access(probe_rows[r].addr, probe_rows[r].bc, probe_rows[r].typed,
                            probe_rows[r].want_any, probe_rows[r].want);
            end
        end

        // random phases: settings at and between their extremes, each pacing in turn
        run_phase(2, 0, 8, MODE_RR, 0, 0, 42);
        run_phase(6, 10, 1, MODE_RANDOM, 70, 0, 42);
        run_phase(3, 4, 4, MODE_RR, 0, 70, 42);
        run_phase(2, 10, 8, MODE_RANDOM, 17, 17, 42);
        run_phase(6, 0, 2, MODE_RR, 70, 0, 42);
        run_phase(5, 3, 8, MODE_RANDOM, 0, 70, 42);
        run_phase(7, 15, 0, MODE_RR, 17, 17, 42);
        run_phase(4, 6, 5, MODE_RANDOM, 0, 0, 42);

        wait_idle();
        if (blocks_due.size() != 0)
        begin
            $error("%0d block results never arrived", blocks_due.size());
            mismatches++;
        end
        $display("run: %0d accesses, %0d block results checked, %0d register writes/settings",
                 accesses_sent, results_seen, settings_count);
        if (mismatches == 0)
            $display("tb_set_assoc_cache_lookup_top: clean");
        else
            $display("tb_set_assoc_cache_lookup_top: errors");
        $finish;
    end

endmodule
